// ===== hw/rtl/fvm_pkg.sv =====
// Package for the valid-mode FIR filter: tap index width, command codes
// and the control group that the top level drives into each tap cell.
// No dependencies; every other filter file but fvm_out_if imports it.
`default_nettype none

package fvm_pkg;

    // Width of the tap index field of an input item.
    localparam int IDX_W = 5;

    // Item command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TAP_WR = 1'b1;

    // Per-cell control from the top level.
    typedef struct packed {
        logic shift;   // take the neighbouring sample into the delay stage
        logic tap_wr;  // load the coefficient on tap_value
    } fvm_cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fvm_in_if.sv =====
// Input channel of the valid-mode FIR filter: valid/ready plus one item.
// Depends on fvm_pkg for the tap index width.
`default_nettype none

interface fvm_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    import fvm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [IDX_W-1:0]              tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          frame_end;

    modport source (output valid, output cmd, output tap_index, output value,
                    output frame_end, input ready);
    modport sink   (input valid, input cmd, input tap_index, input value,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fvm_out_if.sv =====
// Result channel of the valid-mode FIR filter: valid/ready plus one item.
// No dependencies.
`default_nettype none

interface fvm_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered_value;
    logic                          padding;
    logic                          run_last;

    modport source (output valid, output filtered_value, output padding,
                    output run_last, input ready);
    modport sink   (input valid, input filtered_value, input padding,
                    input run_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fvm_cell.sv =====
// One tap cell of the filter chain: a coefficient, one delay stage and a
// partial sum stage that adds this tap's product as the sum passes through.
// Depends on fvm_pkg for the control group.
`default_nettype none

module fvm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fvm_pkg::fvm_cell_ctl_t        ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] tap_value,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    input  wire logic signed [ACC_W-1:0]       sum_in,
    input  wire logic                          tok_in,
    output logic signed [ACC_W-1:0]            sum_out,
    output logic                               tok_out
);
    import fvm_pkg::*;

    logic signed [SAMPLE_BITS-1:0]   tap_reg;
    logic signed [SAMPLE_BITS-1:0]   sample_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic signed [ACC_W-1:0]         sum_reg;
    logic signed [ACC_W-1:0]         sum_next;
    logic                            tok_reg;

    // Coefficient store with no reset; the user must write it before use, the cell does not check.
    always_ff @(posedge clk)
    begin
        if (ctl.tap_wr)
        begin
            tap_reg <= tap_value;
        end
    end

    // Delay stage, cleared by reset and shifted on each accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (ctl.shift)
        begin
            sample_reg <= sample_in;
        end
    end

    // Exact product and the partial sum it joins.
    assign prod     = sample_reg * tap_reg;
    assign sum_next = sum_in + ACC_W'(prod);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // The token marks the cycle in which sum_reg holds a live partial sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    assign sample_out = sample_reg;
    assign sum_out    = sum_reg;
    assign tok_out    = tok_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fvm_round.sv =====
// Output stage of the filter chain: rounds the full-precision sum half up
// to Q1.(SAMPLE_BITS-1) and saturates it, with a registered result.
// Depends on fvm_pkg.
`default_nettype none

module fvm_round #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [ACC_W-1:0]       sum_in,
    input  wire logic                          valid_in,
    output logic signed [SAMPLE_BITS-1:0]      value_out,
    output logic                               valid_out
);
    import fvm_pkg::*;

    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (SAMPLE_BITS - 2);
    localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [ACC_W-1:0]              rounded;
    logic [ACC_W-2*SAMPLE_BITS+1:0] hi_bits;
    logic                          fits;
    logic [SAMPLE_BITS-1:0]        value_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          valid_reg;

    // Round half up, then keep the bits above the fraction; the result fits
    // when every bit from its sign upward agrees.
    always_comb
    begin
        rounded    = sum_in + RND;
        hi_bits    = rounded[ACC_W-1:2*SAMPLE_BITS-2];
        fits       = (&hi_bits) || !(|hi_bits);
        value_next = rounded[2*SAMPLE_BITS-2:SAMPLE_BITS-1];
        if (!fits)
        begin
            value_next = rounded[ACC_W-1] ? NEG_MAX : POS_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    assign value_out = value_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fir_valid_mode_filter.sv =====
// Top level of the valid-mode FIR filter: a chain of tap cells, the
// rounding stage, frame bookkeeping and the result register.
// Depends on fvm_pkg, fvm_in_if, fvm_out_if, fvm_cell and fvm_round.
//
//   Channel    Role    Carries
//   in_items   sink    cmd, tap_index, value, frame_end
//   out_items  source  filtered_value, padding, run_last
//
// A tap write, or a sample that yields no result, leaves the input ready.
// A sample with a full window sets the start register; its partial sum then
// walks the cell chain, one cell a cycle, and passes the rounding register
// before the result reaches the output register.
// End-of-frame zero fill follows, one padding item after another.
// Reset clears the delay line, frame count and control state at once.
// A stalled output holds its item; inputs wait until the final result of
// the previous item is loaded into the output register.
`default_nettype none

module fir_valid_mode_filter #(
    parameter int TAPS        = 21,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fvm_in_if.sink     in_items,
    fvm_out_if.source  out_items
);
    import fvm_pkg::*;

    localparam int ACC_FULL = 2 * SAMPLE_BITS + $clog2(TAPS);
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int FCW      = $clog2(TAPS + 1);
    localparam int PADW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int XIDX_W   = 7;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [FCW-1:0]  fc_reg;
    logic [FCW-1:0]  fc_next;
    logic [FCW-1:0]  fc_inc;
    logic [PADW-1:0] pad_reg;
    logic [PADW-1:0] pad_next;
    logic [PADW-1:0] pad_new;
    logic            filt_pend_reg;
    logic            filt_pend_next;
    logic            start_reg;
    logic            start_next;

    logic            accept;
    logic            smp_acc;
    logic            tap_acc;
    logic            tap_ok;
    logic            do_filt;
    logic            slot_free;
    logic            load;
    logic            load_pad;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_val_reg;
    logic                          out_pad_reg;
    logic                          out_last_reg;
    logic                          out_last_next;

    logic signed [SAMPLE_BITS-1:0] smp  [TAPS];
    logic signed [ACC_W-1:0]       sums [TAPS];
    logic                          toks [TAPS];
    logic signed [SAMPLE_BITS-1:0] rnd_value;
    logic                          rnd_valid;

    // Handshake decode.
    assign in_items.ready = (state_reg == S_IDLE);
    assign accept         = in_items.valid && in_items.ready;
    assign smp_acc        = accept && (in_items.cmd == CMD_SAMPLE);
    assign tap_acc        = accept && (in_items.cmd == CMD_TAP_WR);
    assign tap_ok         = (XIDX_W'(in_items.tap_index) < XIDX_W'(TAPS));

    // Frame count saturates at TAPS; zero fill covers the positions that
    // never had a full window.
    always_comb
    begin
        fc_inc  = (fc_reg == FCW'(TAPS)) ? fc_reg : fc_reg + FCW'(1);
        do_filt = (fc_inc == FCW'(TAPS));
        pad_new = '0;
        if (in_items.frame_end)
        begin
            pad_new = do_filt ? PADW'(TAPS - 1) : PADW'(fc_inc);
        end
    end

    // Cell chain: samples move towards cell 0, sums towards cell TAPS-1.
    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        fvm_cell_ctl_t                 ctl;
        logic signed [SAMPLE_BITS-1:0] s_in;
        logic signed [ACC_W-1:0]       p_in;
        logic                          t_in;

        assign ctl.shift  = smp_acc;
        assign ctl.tap_wr = tap_acc && tap_ok
                            && (XIDX_W'(in_items.tap_index) == XIDX_W'(i));

        if (i == TAPS - 1)
        begin : g_newest
            assign s_in = in_items.value;
        end
        else
        begin : g_older
            assign s_in = smp[i+1];
        end

        if (i == 0)
        begin : g_head
            assign p_in = '0;
            assign t_in = start_reg;
        end
        else
        begin : g_body
            assign p_in = sums[i-1];
            assign t_in = toks[i-1];
        end

        fvm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .tap_value  (in_items.value),
            .sample_in  (s_in),
            .sample_out (smp[i]),
            .sum_in     (p_in),
            .tok_in     (t_in),
            .sum_out    (sums[i]),
            .tok_out    (toks[i])
        );
    end

    fvm_round #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_in    (sums[TAPS-1]),
        .valid_in  (toks[TAPS-1]),
        .value_out (rnd_value),
        .valid_out (rnd_valid)
    );

    // Result loading: the filtered item goes first, then the zero fill.
    assign slot_free = !out_valid_reg || out_items.ready;
    assign load      = (state_reg == S_EMIT) && slot_free;
    assign load_pad  = load && !filt_pend_reg;

    always_comb
    begin
        out_last_next = filt_pend_reg ? (pad_reg == '0) : (pad_reg == PADW'(1));
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        fc_next        = fc_reg;
        pad_next       = pad_reg;
        filt_pend_next = filt_pend_reg;
        start_next     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (smp_acc)
                begin
                    fc_next  = in_items.frame_end ? '0 : fc_inc;
                    pad_next = pad_new;
                    if (do_filt)
                    begin
                        start_next = 1'b1;
                        state_next = S_FILT;
                    end
                    else if (pad_new != '0)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_FILT:
            begin
                if (rnd_valid)
                begin
                    filt_pend_next = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    if (filt_pend_reg)
                    begin
                        filt_pend_next = 1'b0;
                    end
                    else
                    begin
                        pad_next = pad_reg - PADW'(1);
                    end
                    if (out_last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fc_reg        <= '0;
            pad_reg       <= '0;
            filt_pend_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            pad_reg       <= pad_next;
            filt_pend_reg <= filt_pend_next;
            start_reg     <= start_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_items.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_val_reg  <= load_pad ? '0 : rnd_value;
            out_pad_reg  <= load_pad;
            out_last_reg <= out_last_next;
        end
    end

    assign out_items.valid          = out_valid_reg;
    assign out_items.filtered_value = out_val_reg;
    assign out_items.padding        = out_pad_reg;
    assign out_items.run_last       = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fvm_checker.sv =====
// Port-level checks for the valid-mode FIR filter, attached by bind.
// Depends on fvm_pkg and on the ports of fir_valid_mode_filter.
`default_nettype none

module fvm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          in_cmd,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] out_value,
    input wire logic                          out_padding,
    input wire logic                          out_run_last
);
    import fvm_pkg::*;

    // A stalled result keeps its item.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(out_padding) && $stable(out_run_last))
        else $error("result changed while stalled");

    // Zero fill always carries a zero sample.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_padding |-> out_value == '0)
        else $error("padding item with non-zero value");

    // No new item is taken while the previous item's run is unfinished.
    a_run_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_run_last |-> !in_ready)
        else $error("input accepted during an unfinished run");

    // A tap write produces no result.
    a_tap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_TAP_WR) && !out_valid |=> !out_valid)
        else $error("tap write produced a result");

    // Zero fill runs without gaps up to its final item.
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_padding && !out_run_last
            |=> out_valid && out_padding)
        else $error("gap inside zero fill");

endmodule

bind fir_valid_mode_filter fvm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_items.valid),
    .in_ready     (in_items.ready),
    .in_cmd       (in_items.cmd),
    .out_valid    (out_items.valid),
    .out_ready    (out_items.ready),
    .out_value    (out_items.filtered_value),
    .out_padding  (out_items.padding),
    .out_run_last (out_items.run_last)
);

`default_nettype wire

// ===== sim/fir_valid_mode_filter_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the valid-mode FIR filter: a directed table,
// then random frames, checked against an in-bench Q1.15 filter predictor.
// Depends on fvm_pkg, fvm_in_if, fvm_out_if and the filter RTL.

module fir_valid_mode_filter_test;
    import fvm_pkg::*;

    localparam int TAPS        = 21;
    localparam int SB          = 16;
    localparam int ITEMS       = 260;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 2 * TAPS + 8;

    typedef logic signed [SB-1:0] q15_t;

    localparam q15_t Q_MAX = 16'sh7fff;
    localparam q15_t Q_MIN = 16'sh8000;

    // One expected output item.
    typedef struct packed {
        q15_t value;
        logic padding;
        logic run_last;
    } fir_result_t;

    // One row of the directed stimulus; want is used only where typed is set.
    typedef struct {
        logic             op;
        logic [IDX_W-1:0] index;
        q15_t             value;
        logic             last;
        int               reps;
        bit               typed;
        q15_t             want;
    } stim_row_t;

    localparam int ROWS = 24;

    // All taps are zero before this table runs, so only the taps written here count.
    stim_row_t plan [ROWS] = '{
        // Short frames yield only zero fill, one item per sample.
        '{CMD_SAMPLE, 5'd0,  16'sd1,   1'b1, 1,  1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  -16'sd1,  1'b0, 1,  1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd2,   1'b1, 1,  1'b0, 16'sd0},
        // Tap writes: frame end ignored, out-of-range indexes ignored.
        '{CMD_TAP_WR, 5'd20, Q_MIN,    1'b1, 1,  1'b0, 16'sd0},
        '{CMD_TAP_WR, 5'd31, Q_MAX,    1'b0, 1,  1'b0, 16'sd0},
        '{CMD_TAP_WR, 5'd21, -16'sd1,  1'b0, 1,  1'b0, 16'sd0},
        // Fill the window; newest tap is -1.0, so the output is -sample.
        '{CMD_SAMPLE, 5'd0,  16'sd0,   1'b0, 20, 1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  Q_MIN,    1'b0, 1,  1'b1, Q_MAX},
        '{CMD_SAMPLE, 5'd0,  Q_MAX,    1'b0, 1,  1'b1, -16'sd32767},
        '{CMD_SAMPLE, 5'd0,  16'sd1,   1'b0, 1,  1'b1, -16'sd1},
        '{CMD_SAMPLE, 5'd0,  16'sd0,   1'b1, 1,  1'b1, 16'sd0},
        // Newest tap 0.5: halves round up, on both signs.
        '{CMD_TAP_WR, 5'd20, 16'sd16384, 1'b0, 1, 1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd0,   1'b0, 20, 1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd1,   1'b0, 1,  1'b1, 16'sd1},
        '{CMD_SAMPLE, 5'd0,  -16'sd1,  1'b0, 1,  1'b1, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd3,   1'b0, 1,  1'b1, 16'sd2},
        '{CMD_SAMPLE, 5'd0,  -16'sd3,  1'b1, 1,  1'b1, -16'sd1},
        // Tap 0 meets the oldest sample; a frame of exactly TAPS samples.
        '{CMD_TAP_WR, 5'd0,  Q_MAX,    1'b0, 1,  1'b0, 16'sd0},
        '{CMD_TAP_WR, 5'd20, 16'sd0,   1'b0, 1,  1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  Q_MIN,    1'b0, 1,  1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd0,   1'b0, 19, 1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd0,   1'b1, 1,  1'b1, -16'sd32767},
        // A frame one sample short of a full window: zero fill only.
        '{CMD_SAMPLE, 5'd0,  16'sd5,   1'b0, 19, 1'b0, 16'sd0},
        '{CMD_SAMPLE, 5'd0,  16'sd7,   1'b1, 1,  1'b0, 16'sd0}
    };

    logic clk;
    logic rst_n;

    fvm_in_if  #(.SAMPLE_BITS(SB)) in_items ();
    fvm_out_if #(.SAMPLE_BITS(SB)) out_items ();

    fir_valid_mode_filter #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_items  (in_items),
        .out_items (out_items)
    );

    // Predictor state: coefficients, delay line (index 0 oldest) and frame fill.
    q15_t        coef [TAPS];
    q15_t        window [TAPS];
    int          fill;
    fir_result_t result_q [$];

    // Run bookkeeping.
    int  errors;
    int  items_sent;
    int  samples_sent;
    int  taps_written;
    int  results_seen;
    int  fill_seen;
    int  idle_cycles;
    bit  steady;
    bit  hold_req;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Rounded, saturated correlation of the coefficients with the window.
    function automatic q15_t filter_output();
        longint acc = 0;
        for (int i = 0; i < TAPS; i++)
            acc += longint'(coef[i]) * longint'(window[i]);
        acc = (acc + (longint'(1) <<< (SB - 2))) >>> (SB - 1);
        if (acc > longint'(Q_MAX))
            return Q_MAX;
        if (acc < longint'(Q_MIN))
            return Q_MIN;
        return q15_t'(acc);
    endfunction

    // Shift one sample in and queue every output item that it causes.
    function automatic void predict_sample(input q15_t v, input logic last,
                                           input bit typed, input q15_t want);
        fir_result_t r;
        int          full;
        int          pads;
        int          total;
        for (int i = 0; i < TAPS - 1; i++)
            window[i] = window[i + 1];
        window[TAPS - 1] = v;
        if (fill < TAPS)
            fill++;
        full  = (fill == TAPS) ? 1 : 0;
        pads  = last ? ((fill < TAPS - 1) ? fill : TAPS - 1) : 0;
        total = full + pads;
        for (int k = 0; k < total; k++)
        begin
            r.padding  = (k >= full);
            r.value    = r.padding ? q15_t'(0) : (typed ? want : filter_output());
            r.run_last = (k == total - 1);
            result_q.push_back(r);
        end
        if (last)
            fill = 0;
    endfunction

    // Offer one item, after a random gap, and hold it until it is taken.
    task automatic offer_item(input logic op, input logic [IDX_W-1:0] index,
                              input q15_t v, input logic last,
                              input bit typed, input q15_t want);
        while (!steady && $urandom_range(99) < 29)
        begin
            in_items.valid <= 1'b0;
            @(posedge clk);
        end
        in_items.valid     <= 1'b1;
        in_items.cmd       <= op;
        in_items.tap_index <= index;
        in_items.value     <= v;
        in_items.frame_end <= last;
        @(posedge clk);
        while (in_items.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        if (op == CMD_TAP_WR)
        begin
            taps_written++;
            if (index < TAPS)
                coef[index] = v;
        end
        else
        begin
            samples_sent++;
            predict_sample(v, last, typed, want);
        end
    endtask

    // Stop offering and wait until every expected item has come out.
    task automatic drain_results();
        in_items.valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    // Random Q1.15 value: full range, or small when narrow is set, with some extremes.
    function automatic q15_t pick_value(input bit narrow);
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return Q_MIN;
        if (pick < 8)
            return Q_MAX;
        if (pick < 10)
            return q15_t'(0);
        if (pick < 12)
            return -16'sd1;
        if (narrow)
            return q15_t'(int'($urandom_range(4095)) - 2048);
        return q15_t'($urandom);
    endfunction

    // Receiver: random ready, steady stretches, and long hold-offs on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_items.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_items.ready <= 1'b0;
            end
            else
                out_items.ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    // Output checker: each item against the oldest expectation.
    always @(posedge clk)
    begin
        fir_result_t want;
        if (rst_n && out_items.valid === 1'b1 && out_items.ready === 1'b1)
        begin
            results_seen++;
            if (out_items.padding === 1'b1)
                fill_seen++;
            if (result_q.size() == 0)
            begin
                $error("unexpected output item: filtered_value %0d padding %0b run_last %0b",
                       out_items.filtered_value, out_items.padding, out_items.run_last);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (out_items.filtered_value !== want.value)
                begin
                    $error("filtered_value: expected %0d, got %0d",
                           want.value, out_items.filtered_value);
                    errors++;
                end
                if (out_items.padding !== want.padding)
                begin
                    $error("padding: expected %0b, got %0b", want.padding, out_items.padding);
                    errors++;
                end
                if (out_items.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_last, out_items.run_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either channel.
    always @(posedge clk)
    begin
        if ((in_items.valid === 1'b1 && in_items.ready === 1'b1) ||
            (out_items.valid === 1'b1 && out_items.ready === 1'b1) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        int  rand_items;
        int  frame_len;
        int  batch;
        bit  narrow;
        bit  hold_done;
        bit  drain_done;
        logic [IDX_W-1:0] index;

        errors       = 0;
        items_sent   = 0;
        samples_sent = 0;
        taps_written = 0;
        results_seen = 0;
        fill_seen    = 0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        fill         = 0;
        rand_items   = 0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        for (int i = 0; i < TAPS; i++)
        begin
            coef[i]   = '0;
            window[i] = '0;
        end

        rst_n              = 1'b0;
        in_items.valid     <= 1'b0;
        in_items.cmd       <= CMD_SAMPLE;
        in_items.tap_index <= '0;
        in_items.value     <= '0;
        in_items.frame_end <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every tap is written before any full window can read it.
        for (int i = 0; i < TAPS; i++)
            offer_item(CMD_TAP_WR, IDX_W'(i), q15_t'(0), 1'b0, 1'b0, q15_t'(0));

        // Directed table.
        foreach (plan[r])
            for (int n = 0; n < plan[r].reps; n++)
                offer_item(plan[r].op, plan[r].index, plan[r].value, plan[r].last,
                           plan[r].typed, plan[r].want);

        // Random part: mostly whole frames, some tap rewrites, a little noise.
        while (rand_items < ITEMS)
        begin
            if ($urandom_range(99) < 20)
            begin
                batch  = $urandom_range(1, 6);
                narrow = 1'($urandom_range(1));
                for (int b = 0; b < batch; b++)
                begin
                    index = IDX_W'($urandom_range(TAPS - 1));
                    offer_item(CMD_TAP_WR, index, pick_value(narrow),
                               1'($urandom), 1'b0, q15_t'(0));
                    rand_items++;
                end
            end
            else
            begin
                case ($urandom_range(99)) inside
                    [0:29]:  frame_len = $urandom_range(1, TAPS - 1);
                    [30:84]: frame_len = $urandom_range(TAPS, 45);
                    default: frame_len = $urandom_range(46, 70);
                endcase
                narrow = ($urandom_range(99) < 30);
                for (int s = 0; s < frame_len; s++)
                begin
                    // Receiver holds off while samples keep coming.
                    if (!hold_done && rand_items >= 60)
                    begin
                        hold_req  = 1'b1;
                        hold_done = 1'b1;
                    end
                    steady = (rand_items >= 110 && rand_items < 170);
                    // Sender stops until the output has caught up.
                    if (!drain_done && rand_items >= 200)
                    begin
                        drain_results();
                        drain_done = 1'b1;
                    end
                    // Stray tap write beyond the last tap: ignored.
                    if ($urandom_range(99) < 4)
                        offer_item(CMD_TAP_WR, IDX_W'($urandom_range(TAPS, 31)),
                                   q15_t'($urandom), 1'($urandom), 1'b0, q15_t'(0));
                    // Most frames close properly; some run on into the next.
                    offer_item(CMD_SAMPLE, IDX_W'($urandom), pick_value(narrow),
                               (s == frame_len - 1) && ($urandom_range(99) < 90),
                               1'b0, q15_t'(0));
                    rand_items++;
                end
            end
        end
        steady = 1'b0;

        // Let everything drain, then watch for stray output items.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d items in (%0d samples, %0d tap writes), %0d items out",
                 items_sent, samples_sent, taps_written, results_seen);
        $display("summary: %0d zero-fill items, %0d mismatches", fill_seen, errors);
        if (errors == 0 && result_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fvm_pkg.sv
hw/rtl/fvm_in_if.sv
hw/rtl/fvm_out_if.sv
hw/rtl/fvm_cell.sv
hw/rtl/fvm_round.sv
hw/rtl/fir_valid_mode_filter.sv
hw/rtl/fvm_checker.sv
sim/fir_valid_mode_filter_test.sv
